[hdl/pfs_pkg.sv]
package pfs_pkg;

    localparam int PIX_W       = 17;
    localparam int IN_TDATA_W  = 24;
    localparam int CNT_W       = 25;
    localparam int SUM_W       = 42;
    localparam int MAG_W       = 41;
    localparam int SQ_W        = 33;
    localparam int SSQ_W       = 57;
    localparam int PROD_W      = 81;
    localparam int MB_W        = 41;
    localparam int MEAN_FRAC   = 8;
    localparam int DIV_W       = MAG_W + MEAN_FRAC;
    localparam int MEAN_W      = 25;
    localparam int VAR_W       = 32;
    localparam int STD_W       = 16;
    localparam int OUT_FIELD_W = 2 * PIX_W + CNT_W + MEAN_W + VAR_W + STD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int STEP_W      = 6;

    localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(16777216);

    localparam logic [PIX_W-1:0] PIX_LARGEST  = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic [PIX_W-1:0] PIX_SMALLEST = {1'b1, {(PIX_W-1){1'b0}}};

    localparam logic [STEP_W-1:0] STEPS_MUL_NQ   = STEP_W'(CNT_W);
    localparam logic [STEP_W-1:0] STEPS_MUL_SS   = STEP_W'(MAG_W);
    localparam logic [STEP_W-1:0] STEPS_MUL_NN   = STEP_W'(CNT_W);
    localparam logic [STEP_W-1:0] STEPS_DIV_MEAN = STEP_W'(DIV_W);
    localparam logic [STEP_W-1:0] STEPS_DIV_VAR  = STEP_W'(VAR_W);
    localparam logic [STEP_W-1:0] STEPS_SQRT     = STEP_W'(STD_W);

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_SNAP,
        ST_MUL_NQ,
        ST_MUL_SS,
        ST_MUL_NN,
        ST_DIV_MEAN,
        ST_DIV_VAR,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SNAP,
        OP_MUL_NQ_LOAD,
        OP_MUL_SS_LOAD,
        OP_MUL_NN_LOAD,
        OP_MUL_STEP,
        OP_DIV_MEAN_LOAD,
        OP_DIV_VAR_LOAD,
        OP_DIV_STEP,
        OP_SQRT_LOAD,
        OP_SQRT_STEP,
        OP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        logic   in_ready;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic last_pending;
        logic out_blocked;
    } t_dp_status;

endpackage

[hdl/pixel_frame_statistics_top.sv]
// after a last pixel the controller steps through snapshot, three multiply, two divide,
// square root and output load states before o_m_tvalid; throughput: one pixel per cycle
// inside a frame; the input stalls while the shared shift-add multiplier, restoring
// divider and square root unit work through the frame one bit per cycle
// reset: i_rst_n synchronous active low, clears accumulators, controller and result valid
module pixel_frame_statistics_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [pfs_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // pixel
    input  logic                            i_s_tlast,   // last
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [pfs_pkg::OUT_TDATA_W-1:0] o_m_tdata    // min_value, max_value, pixel_total,
                                                         // mean_q8, variance, std_dev
);

    pfs_pkg::t_dp_cmd    w_cmd;
    pfs_pkg::t_dp_status w_status;

    pfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    pfs_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_s_tvalid (i_s_tvalid),
        .i_pixel    (i_s_tdata[pfs_pkg::PIX_W-1:0]),
        .i_last     (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    assign o_s_tready = w_cmd.in_ready;

endmodule

[hdl/pfs_ctrl.sv]
module pfs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfs_pkg::t_dp_status   i_status,
    output pfs_pkg::t_dp_cmd      o_cmd
);

    pfs_pkg::t_state                r_state;
    pfs_pkg::t_state                n_state;
    logic [pfs_pkg::STEP_W-1:0]     r_cnt;
    logic [pfs_pkg::STEP_W-1:0]     n_cnt;
    logic [pfs_pkg::STEP_W-1:0]     w_limit;
    logic                           w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfs_pkg::ST_ACCUM;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        case (r_state)
            pfs_pkg::ST_MUL_NQ:   w_limit = pfs_pkg::STEPS_MUL_NQ;
            pfs_pkg::ST_MUL_SS:   w_limit = pfs_pkg::STEPS_MUL_SS;
            pfs_pkg::ST_MUL_NN:   w_limit = pfs_pkg::STEPS_MUL_NN;
            pfs_pkg::ST_DIV_MEAN: w_limit = pfs_pkg::STEPS_DIV_MEAN;
            pfs_pkg::ST_DIV_VAR:  w_limit = pfs_pkg::STEPS_DIV_VAR;
            pfs_pkg::ST_SQRT:     w_limit = pfs_pkg::STEPS_SQRT;
            default:              w_limit = '0;
        endcase
    end

    assign w_done = (r_cnt == w_limit);

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            pfs_pkg::ST_ACCUM: begin
                if (i_status.last_pending) begin
                    n_state = pfs_pkg::ST_SNAP;
                end
            end
            pfs_pkg::ST_SNAP: begin
                n_state = pfs_pkg::ST_MUL_NQ;
            end
            pfs_pkg::ST_MUL_NQ, pfs_pkg::ST_MUL_SS, pfs_pkg::ST_MUL_NN,
            pfs_pkg::ST_DIV_MEAN, pfs_pkg::ST_DIV_VAR, pfs_pkg::ST_SQRT: begin
                if (w_done) begin
                    case (r_state)
                        pfs_pkg::ST_MUL_NQ:   n_state = pfs_pkg::ST_MUL_SS;
                        pfs_pkg::ST_MUL_SS:   n_state = pfs_pkg::ST_MUL_NN;
                        pfs_pkg::ST_MUL_NN:   n_state = pfs_pkg::ST_DIV_MEAN;
                        pfs_pkg::ST_DIV_MEAN: n_state = pfs_pkg::ST_DIV_VAR;
                        pfs_pkg::ST_DIV_VAR:  n_state = pfs_pkg::ST_SQRT;
                        default:              n_state = pfs_pkg::ST_OUT;
                    endcase
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            pfs_pkg::ST_OUT: begin
                if (!i_status.out_blocked) begin
                    n_state = pfs_pkg::ST_ACCUM;
                end
            end
            default: begin
                n_state = pfs_pkg::ST_ACCUM;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = pfs_pkg::OP_NONE;
        case (r_state)
            pfs_pkg::ST_ACCUM: begin
                o_cmd.in_ready = !i_status.last_pending;
            end
            pfs_pkg::ST_SNAP: begin
                o_cmd.op = pfs_pkg::OP_SNAP;
            end
            pfs_pkg::ST_MUL_NQ: begin
                o_cmd.op = (r_cnt == '0) ? pfs_pkg::OP_MUL_NQ_LOAD : pfs_pkg::OP_MUL_STEP;
            end
            pfs_pkg::ST_MUL_SS: begin
                o_cmd.op = (r_cnt == '0) ? pfs_pkg::OP_MUL_SS_LOAD : pfs_pkg::OP_MUL_STEP;
            end
            pfs_pkg::ST_MUL_NN: begin
                o_cmd.op = (r_cnt == '0) ? pfs_pkg::OP_MUL_NN_LOAD : pfs_pkg::OP_MUL_STEP;
            end
            pfs_pkg::ST_DIV_MEAN: begin
                o_cmd.op = (r_cnt == '0) ? pfs_pkg::OP_DIV_MEAN_LOAD : pfs_pkg::OP_DIV_STEP;
            end
            pfs_pkg::ST_DIV_VAR: begin
                o_cmd.op = (r_cnt == '0) ? pfs_pkg::OP_DIV_VAR_LOAD : pfs_pkg::OP_DIV_STEP;
            end
            pfs_pkg::ST_SQRT: begin
                o_cmd.op = (r_cnt == '0) ? pfs_pkg::OP_SQRT_LOAD : pfs_pkg::OP_SQRT_STEP;
            end
            pfs_pkg::ST_OUT: begin
                o_cmd.op = i_status.out_blocked ? pfs_pkg::OP_NONE : pfs_pkg::OP_OUT_LOAD;
            end
            default: begin
                o_cmd.op = pfs_pkg::OP_NONE;
            end
        endcase
    end

    a_no_accept_behind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.last_pending |-> !o_cmd.in_ready)
        else $error("transaction accepted while a last pixel is in the pipe");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == pfs_pkg::OP_OUT_LOAD) |-> !i_status.out_blocked)
        else $error("result register overwritten before its transaction");

endmodule

[hdl/pfs_dpath.sv]
module pfs_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pfs_pkg::t_dp_cmd                i_cmd,
    output pfs_pkg::t_dp_status             o_status,
    input  logic                            i_s_tvalid,
    input  logic [pfs_pkg::PIX_W-1:0]       i_pixel,
    input  logic                            i_last,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [pfs_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int PIX_W  = pfs_pkg::PIX_W;
    localparam int CNT_W  = pfs_pkg::CNT_W;
    localparam int SUM_W  = pfs_pkg::SUM_W;
    localparam int MAG_W  = pfs_pkg::MAG_W;
    localparam int SQ_W   = pfs_pkg::SQ_W;
    localparam int SSQ_W  = pfs_pkg::SSQ_W;
    localparam int PROD_W = pfs_pkg::PROD_W;
    localparam int MB_W   = pfs_pkg::MB_W;
    localparam int DIV_W  = pfs_pkg::DIV_W;
    localparam int MEAN_W = pfs_pkg::MEAN_W;
    localparam int VAR_W  = pfs_pkg::VAR_W;
    localparam int STD_W  = pfs_pkg::STD_W;
    localparam int PAD_W  = pfs_pkg::OUT_TDATA_W - pfs_pkg::OUT_FIELD_W;

    logic                   w_accept;
    logic [PIX_W-1:0]       w_px_mag;
    logic [2*PIX_W-1:0]     w_px_sq;

    // input stage with square
    logic                   r_a_valid;
    logic                   r_a_last;
    logic [PIX_W-1:0]       r_a_px;
    logic [SQ_W-1:0]        r_a_sq;

    // running accumulators
    logic [CNT_W-1:0]       r_count;
    logic [PIX_W-1:0]       r_min;
    logic [PIX_W-1:0]       r_max;
    logic [SUM_W-1:0]       r_sum;
    logic [SSQ_W-1:0]       r_ssq;
    logic                   w_room;
    logic [SUM_W-1:0]       w_sum_abs;

    // frame snapshot
    logic [CNT_W-1:0]       r_n;
    logic                   r_neg;
    logic [MAG_W-1:0]       r_mag;
    logic [SSQ_W-1:0]       r_qs;
    logic [PIX_W-1:0]       r_smin;
    logic [PIX_W-1:0]       r_smax;

    // shift-add multiplier
    logic [SSQ_W-1:0]       r_ma;
    logic [MB_W-1:0]        r_mb;
    logic [PROD_W-1:0]      r_prod;
    logic [PROD_W-1:0]      w_mul_add;
    logic [PROD_W-1:0]      r_nq;
    logic [PROD_W-1:0]      r_d;

    // restoring divider
    logic [DIV_W-1:0]       r_rem;
    logic [DIV_W-1:0]       r_dsh;
    logic [DIV_W-1:0]       r_q;
    logic [DIV_W-1:0]       r_dvs;
    logic [DIV_W-1:0]       r_dd;
    logic                   r_sat;
    logic [DIV_W:0]         w_trial;
    logic [DIV_W:0]         w_diff;
    logic                   w_ge;
    logic [MEAN_W:0]        w_mmag;
    logic [MEAN_W:0]        w_mean_full;
    logic [MEAN_W-1:0]      r_mean;

    // square root
    logic [VAR_W-1:0]       w_var;
    logic [VAR_W-1:0]       r_var;
    logic [VAR_W-1:0]       r_sv;
    logic [VAR_W-1:0]       r_root;
    logic [VAR_W-1:0]       r_sbit;
    logic [VAR_W-1:0]       w_rb;

    // result register
    logic                   r_out_valid;
    logic [PIX_W-1:0]       r_o_min;
    logic [PIX_W-1:0]       r_o_max;
    logic [CNT_W-1:0]       r_o_n;
    logic [MEAN_W-1:0]      r_o_mean;
    logic [VAR_W-1:0]       r_o_var;
    logic [STD_W-1:0]       r_o_std;
    logic [VAR_W:0]         w_chk_lo;
    logic [VAR_W:0]         w_chk_hi;

    assign w_accept = i_s_tvalid & i_cmd.in_ready;
    assign w_px_mag = i_pixel[PIX_W-1] ? (~i_pixel + PIX_W'(1)) : i_pixel;
    assign w_px_sq  = w_px_mag * w_px_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_px   <= i_pixel;
            r_a_last <= i_last;
            r_a_sq   <= w_px_sq[SQ_W-1:0];
        end
    end

    assign w_room = (r_count < pfs_pkg::MAX_PIXELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == pfs_pkg::OP_SNAP) begin
            r_count <= '0;
            r_min   <= pfs_pkg::PIX_LARGEST;
            r_max   <= pfs_pkg::PIX_SMALLEST;
            r_sum   <= '0;
            r_ssq   <= '0;
        end else if (r_a_valid && w_room) begin
            r_count <= r_count + 1'b1;
            if ($signed(r_a_px) < $signed(r_min)) begin
                r_min <= r_a_px;
            end
            if ($signed(r_a_px) > $signed(r_max)) begin
                r_max <= r_a_px;
            end
            r_sum <= r_sum + {{(SUM_W-PIX_W){r_a_px[PIX_W-1]}}, r_a_px};
            r_ssq <= r_ssq + {{(SSQ_W-SQ_W){1'b0}}, r_a_sq};
        end
    end

    assign w_sum_abs = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pfs_pkg::OP_SNAP) begin
            r_n    <= r_count;
            r_neg  <= r_sum[SUM_W-1];
            r_mag  <= w_sum_abs[MAG_W-1:0];
            r_qs   <= r_ssq;
            r_smin <= r_min;
            r_smax <= r_max;
        end
    end

    assign w_mul_add = r_mb[MB_W-1] ? {{(PROD_W-SSQ_W){1'b0}}, r_ma} : '0;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pfs_pkg::OP_MUL_NQ_LOAD: begin
                r_ma   <= r_qs;
                r_mb   <= {r_n, {(MB_W-CNT_W){1'b0}}};
                r_prod <= '0;
            end
            pfs_pkg::OP_MUL_SS_LOAD: begin
                r_nq   <= r_prod;
                r_ma   <= {{(SSQ_W-MAG_W){1'b0}}, r_mag};
                r_mb   <= r_mag;
                r_prod <= '0;
            end
            pfs_pkg::OP_MUL_NN_LOAD: begin
                r_d    <= (r_nq >= r_prod) ? (r_nq - r_prod) : '0;
                r_ma   <= {{(SSQ_W-CNT_W){1'b0}}, r_n};
                r_mb   <= {r_n, {(MB_W-CNT_W){1'b0}}};
                r_prod <= '0;
            end
            pfs_pkg::OP_MUL_STEP: begin
                r_prod <= {r_prod[PROD_W-2:0], 1'b0} + w_mul_add;
                r_mb   <= {r_mb[MB_W-2:0], 1'b0};
            end
            default: begin
            end
        endcase
    end

    assign w_trial     = {r_rem, r_dsh[DIV_W-1]};
    assign w_diff      = w_trial - {1'b0, r_dvs};
    assign w_ge        = (w_trial >= {1'b0, r_dvs});
    assign w_mmag      = r_q[MEAN_W:0] + {{MEAN_W{1'b0}}, (r_rem != '0)};
    assign w_mean_full = r_neg ? (~w_mmag + (MEAN_W+1)'(1)) : r_q[MEAN_W:0];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pfs_pkg::OP_DIV_MEAN_LOAD: begin
                r_dd  <= r_prod[DIV_W-1:0];
                r_rem <= '0;
                r_dsh <= {r_mag, {pfs_pkg::MEAN_FRAC{1'b0}}};
                r_q   <= '0;
                r_dvs <= {{(DIV_W-CNT_W){1'b0}}, r_n};
            end
            pfs_pkg::OP_DIV_VAR_LOAD: begin
                r_mean <= w_mean_full[MEAN_W-1:0];
                r_sat  <= (r_d[PROD_W-1:VAR_W] >= r_dd);
                r_rem  <= r_d[PROD_W-1:VAR_W];
                r_dsh  <= {r_d[VAR_W-1:0], {(DIV_W-VAR_W){1'b0}}};
                r_q    <= '0;
                r_dvs  <= r_dd;
            end
            pfs_pkg::OP_DIV_STEP: begin
                r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                r_dsh <= {r_dsh[DIV_W-2:0], 1'b0};
                r_q   <= {r_q[DIV_W-2:0], w_ge};
            end
            default: begin
            end
        endcase
    end

    assign w_var = r_sat ? '1 : r_q[VAR_W-1:0];
    assign w_rb  = r_root + r_sbit;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pfs_pkg::OP_SQRT_LOAD: begin
                r_var  <= w_var;
                r_sv   <= w_var;
                r_root <= '0;
                r_sbit <= VAR_W'(1) << (VAR_W - 2);
            end
            pfs_pkg::OP_SQRT_STEP: begin
                if (r_sv >= w_rb) begin
                    r_sv   <= r_sv - w_rb;
                    r_root <= (r_root >> 1) + r_sbit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == pfs_pkg::OP_OUT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pfs_pkg::OP_OUT_LOAD) begin
            r_o_min  <= r_smin;
            r_o_max  <= r_smax;
            r_o_n    <= r_n;
            r_o_mean <= r_mean;
            r_o_var  <= r_var;
            r_o_std  <= r_root[STD_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_o_std, r_o_var, r_o_mean, r_o_n, r_o_max, r_o_min};

    assign o_status.last_pending = r_a_valid & r_a_last;
    assign o_status.out_blocked  = r_out_valid & ~i_m_tready;

    assign w_chk_lo = (VAR_W+1)'(r_o_std) * (VAR_W+1)'(r_o_std);
    assign w_chk_hi = ((VAR_W+1)'(r_o_std) + (VAR_W+1)'(1)) *
                      ((VAR_W+1)'(r_o_std) + (VAR_W+1)'(1));

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pfs_pkg::MAX_PIXELS)
        else $error("pixel count beyond frame limit");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_o_min) <= $signed(r_o_max)))
        else $error("result minimum above maximum");

    a_root_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (w_chk_lo <= {1'b0, r_o_var} && w_chk_hi > {1'b0, r_o_var}))
        else $error("standard deviation is not the floor root of variance");

endmodule
